[rtl/sensorless_bldc_commutation_sequencer_defines.svh]
// Assertion macros used by the checker file
`ifndef SENSORLESS_BLDC_COMMUTATION_SEQUENCER_DEFINES_SVH
`define SENSORLESS_BLDC_COMMUTATION_SEQUENCER_DEFINES_SVH
// Implication checked on every clock edge outside reset
`define SBC_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication outside reset
`define SBC_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

[rtl/sbc_pkg.sv]
// Shared types, constants and step tables for the commutation sequencer
package sbc_pkg;

    typedef enum logic [2:0] {
        MS_OFF    = 3'd0,
        MS_ALIGN  = 3'd1,
        MS_RAMP   = 3'd2,
        MS_CLOSED = 3'd3,
        MS_DELAY  = 3'd4
    } motor_state_t;

    typedef enum logic [2:0] {
        EV_START   = 3'd0,
        EV_STOP    = 3'd1,
        EV_EXPIRE  = 3'd2,
        EV_CAPTURE = 3'd3,
        EV_DUTY_UP = 3'd4,
        EV_DUTY_DN = 3'd5
    } event_t;

    typedef enum logic [2:0] {
        REG_START_PERIOD = 3'd0,
        REG_PERIOD_STEP  = 3'd1,
        REG_START_DUTY   = 3'd2,
        REG_DUTY_STEP    = 3'd3,
        REG_RAMP_LEN     = 3'd4,
        REG_CL_DUTY      = 3'd5,
        REG_DELAY_FACTOR = 3'd6,
        REG_ALIGN_TICKS  = 3'd7
    } reg_index_t;

    typedef enum logic [2:0] {
        CS_IDLE   = 3'd0,
        CS_EXEC   = 3'd1,
        CS_DIV    = 3'd2,
        CS_FINISH = 3'd3,
        CS_OUT    = 3'd4
    } ctrl_state_t;

    localparam logic [11:0] DELAY_MAX    = 12'd2500;
    localparam logic [11:0] DELAY_MIN    = 12'd50;
    localparam logic [7:0]  FACTOR_MIN   = 8'd4;
    localparam logic [7:0]  DUTY_INT_MAX = 8'd255;
    localparam int          CAP_BITS     = 16;

    // Controller to datapath commands
    typedef struct packed {
        logic load_item;
        logic exec;
        logic div_start;
        logic div_step;
        logic finish;
    } dp_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic need_div;
        logic div_done;
    } dp_status_t;

    function automatic logic [1:0] high_of(input logic [2:0] s);
        case (s)
            3'd0: high_of = 2'd0;
            3'd1: high_of = 2'd1;
            3'd2: high_of = 2'd1;
            3'd3: high_of = 2'd2;
            3'd4: high_of = 2'd2;
            3'd5: high_of = 2'd0;
            default: high_of = 2'd0;
        endcase
    endfunction

    function automatic logic [1:0] low_of(input logic [2:0] s);
        case (s)
            3'd0: low_of = 2'd2;
            3'd1: low_of = 2'd2;
            3'd2: low_of = 2'd0;
            3'd3: low_of = 2'd0;
            3'd4: low_of = 2'd1;
            3'd5: low_of = 2'd1;
            default: low_of = 2'd0;
        endcase
    endfunction

    function automatic logic [1:0] comp_of(input logic [2:0] s);
        case (s)
            3'd0: comp_of = 2'd1;
            3'd1: comp_of = 2'd0;
            3'd2: comp_of = 2'd2;
            3'd3: comp_of = 2'd1;
            3'd4: comp_of = 2'd0;
            3'd5: comp_of = 2'd2;
            default: comp_of = 2'd0;
        endcase
    endfunction

endpackage

[rtl/sbc_ctrl.sv]
// Sequencing controller: event execution, serial divide, result hand-off
module sbc_ctrl
    import sbc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_beat,
    input  logic       out_taken,
    input  dp_status_t status,
    output dp_cmd_t    cmd,
    output logic       in_ready,
    output logic       out_valid
);

    ctrl_state_t state_reg, state_next;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= CS_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        case (state_reg)
            CS_IDLE: begin
                in_ready = 1'b1;
                if (in_beat) begin
                    cmd.load_item = 1'b1;
                    state_next    = CS_EXEC;
                end
            end
            CS_EXEC: begin
                if (status.need_div) begin
                    cmd.div_start = 1'b1;
                    state_next    = CS_DIV;
                end else begin
                    cmd.exec   = 1'b1;
                    state_next = CS_OUT;
                end
            end
            CS_DIV: begin
                cmd.div_step = 1'b1;
                if (status.div_done) begin
                    state_next = CS_FINISH;
                end
            end
            CS_FINISH: begin
                cmd.finish = 1'b1;
                state_next = CS_OUT;
            end
            CS_OUT: begin
                out_valid = 1'b1;
                if (out_taken) begin
                    state_next = CS_IDLE;
                end
            end
            default: begin
                state_next = CS_IDLE;
            end
        endcase
    end

endmodule

[rtl/sbc_datapath.sv]
// Datapath: configuration, motor state, serial divider and result register
module sbc_datapath
    import sbc_pkg::*;
#(
    parameter int TIMER_BITS = 16
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  dp_cmd_t                 cmd,
    output dp_status_t              status,
    input  logic [2:0]              in_mode,
    input  logic [CAP_BITS-1:0]     in_capture,
    input  logic                    cfg_we,
    input  logic [2:0]              cfg_index,
    input  logic [23:0]             cfg_data,
    output logic [39:0]             result
);

    localparam int TB = TIMER_BITS;
    localparam logic [TB-1:0] TMAX = {TB{1'b1}};
    localparam int CW = 5;

    // Configuration registers
    logic [15:0] start_period_reg, period_step_reg, start_duty_reg, duty_step_reg;
    logic [15:0] cl_duty_reg;
    logic [7:0]  ramp_len_reg, delay_factor_reg;
    logic [23:0] align_ticks_reg;

    // Motor state
    motor_state_t ms_reg, ms_next;
    logic [2:0]   step_reg, step_next;
    logic [15:0]  interval_reg, interval_next;
    logic [15:0]  duty_reg, duty_next;
    logic [7:0]   ramp_cnt_reg, ramp_cnt_next;
    logic [7:0]   align_cnt_reg, align_cnt_next;
    logic [15:0]  period_reg, period_next;

    // Item and divider
    logic [2:0]   ev_reg;
    logic [15:0]  cap_reg;
    logic [15:0]  quo_reg, rem_reg;
    logic [CW-1:0] div_cnt_reg;
    logic [7:0]   div_reg;
    logic [39:0]  result_reg, result_next;

    // Derived values
    logic [7:0]   wraps;
    logic [TB-1:0] rest;
    logic [33:0]  cmp_wide;
    logic         load, restart;
    logic [16:0]  duty_sum;
    logic [TB-1:0] cmp_sat;
    logic [2:0]   step_adv;
    logic         cap_ok;
    logic [16:0]  rem_shift;
    logic [15:0]  delay_q;

    always_comb begin
        if (TB >= 24) begin
            wraps = 8'd0;
            rest  = TB'(align_ticks_reg);
        end else begin
            wraps = (|(align_ticks_reg >> TB) & ((align_ticks_reg >> TB) > 24'd255))
                    ? 8'd255 : 8'(align_ticks_reg >> TB);
            rest  = TB'(align_ticks_reg);
        end
    end

    assign step_adv = (step_reg >= 3'd5) ? 3'd0 : step_reg + 3'd1;
    assign cap_ok   = (ms_reg == MS_CLOSED) && (cap_reg >= (period_reg >> 2));
    assign status.need_div = (ev_reg == EV_CAPTURE) && cap_ok;
    assign status.div_done = (div_cnt_reg == CW'(1));
    assign duty_sum = {1'b0, duty_reg} + {1'b0, duty_step_reg};
    assign rem_shift = {rem_reg, quo_reg[15]};
    assign delay_q  = (quo_reg > 16'(DELAY_MAX)) ? 16'(DELAY_MAX) : quo_reg;

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_period_reg <= 16'd50000;
            period_step_reg  <= 16'd900;
            start_duty_reg   <= 16'd3264;
            duty_step_reg    <= 16'd20;
            ramp_len_reg     <= 8'd50;
            cl_duty_reg      <= 16'd3264;
            delay_factor_reg <= 8'd4;
            align_ticks_reg  <= 24'd500000;
        end else if (cfg_we) begin
            case (reg_index_t'(cfg_index))
                REG_START_PERIOD: start_period_reg <= cfg_data[15:0];
                REG_PERIOD_STEP:  period_step_reg  <= cfg_data[15:0];
                REG_START_DUTY:   start_duty_reg   <= cfg_data[15:0];
                REG_DUTY_STEP:    duty_step_reg    <= cfg_data[15:0];
                REG_RAMP_LEN:     ramp_len_reg     <= cfg_data[7:0];
                REG_CL_DUTY:      cl_duty_reg      <= cfg_data[15:0];
                REG_DELAY_FACTOR: delay_factor_reg <= cfg_data[7:0];
                REG_ALIGN_TICKS:  align_ticks_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // Event execution
    always_comb begin
        ms_next        = ms_reg;
        step_next      = step_reg;
        interval_next  = interval_reg;
        duty_next      = duty_reg;
        ramp_cnt_next  = ramp_cnt_reg;
        align_cnt_next = align_cnt_reg;
        period_next    = period_reg;
        cmp_wide       = '0;
        load           = 1'b0;
        restart        = 1'b0;
        if (cmd.finish) begin
            // closed-loop capture after divide
            period_next = cap_reg;
            restart     = 1'b1;
            if (delay_q < 16'(DELAY_MIN)) begin
                step_next = step_adv;
            end else begin
                cmp_wide = 34'(delay_q);
                load     = 1'b1;
                ms_next  = MS_DELAY;
            end
        end else begin
            case (ev_reg)
                EV_START: begin
                    interval_next = start_period_reg;
                    duty_next     = start_duty_reg;
                    ramp_cnt_next = 8'd0;
                    step_next     = 3'd0;
                    restart       = 1'b1;
                    load          = 1'b1;
                    if (wraps != 8'd0) begin
                        cmp_wide       = 34'(TMAX);
                        align_cnt_next = 8'd1;
                    end else begin
                        cmp_wide       = 34'(rest);
                        align_cnt_next = 8'd0;
                    end
                    ms_next = MS_ALIGN;
                end
                EV_STOP: ms_next = MS_OFF;
                EV_EXPIRE: begin
                    case (ms_reg)
                        MS_ALIGN: begin
                            step_next = 3'd0;
                            restart   = 1'b1;
                            load      = 1'b1;
                            if (align_cnt_reg < wraps) begin
                                cmp_wide       = 34'(TMAX);
                                align_cnt_next = align_cnt_reg + 8'd1;
                            end else begin
                                cmp_wide = 34'(rest);
                                ms_next  = MS_RAMP;
                            end
                        end
                        MS_RAMP: begin
                            step_next = step_adv;
                            restart   = 1'b1;
                            load      = 1'b1;
                            if (ramp_cnt_reg < ramp_len_reg) begin
                                cmp_wide      = 34'(interval_reg);
                                ramp_cnt_next = ramp_cnt_reg + 8'd1;
                                interval_next = (interval_reg > period_step_reg)
                                                ? interval_reg - period_step_reg : 16'd0;
                                duty_next     = duty_sum[16] ? 16'hFFFF : duty_sum[15:0];
                            end else begin
                                cmp_wide    = 34'({interval_reg, 2'b00});
                                ms_next     = MS_CLOSED;
                                duty_next   = cl_duty_reg;
                                period_next = interval_reg;
                            end
                        end
                        MS_DELAY: begin
                            step_next = step_adv;
                            ms_next   = MS_CLOSED;
                        end
                        default: ;
                    endcase
                end
                EV_DUTY_UP: begin
                    if (duty_reg[15:8] < DUTY_INT_MAX) duty_next = duty_reg + 16'd256;
                end
                EV_DUTY_DN: begin
                    if (duty_reg[15:8] != 8'd0) duty_next = duty_reg - 16'd256;
                end
                default: ;
            endcase
        end
        cmp_sat = (cmp_wide > 34'(TMAX)) ? TMAX : cmp_wide[TB-1:0];
        result_next = {restart, load, 16'(cmp_sat), duty_next[15:8],
                       ~step_next[0], comp_of(step_next), low_of(step_next),
                       high_of(step_next), (ms_next != MS_OFF), step_next,
                       3'(ms_next)};
    end

    // State update
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ms_reg        <= MS_OFF;
            step_reg      <= 3'd0;
            interval_reg  <= 16'd0;
            duty_reg      <= 16'd0;
            ramp_cnt_reg  <= 8'd0;
            align_cnt_reg <= 8'd0;
            period_reg    <= 16'd0;
            div_cnt_reg   <= '0;
        end else begin
            if (cmd.exec || cmd.finish) begin
                ms_reg        <= ms_next;
                step_reg      <= step_next;
                interval_reg  <= interval_next;
                duty_reg      <= duty_next;
                ramp_cnt_reg  <= ramp_cnt_next;
                align_cnt_reg <= align_cnt_next;
                period_reg    <= period_next;
            end
            if (cmd.div_start) begin
                div_cnt_reg <= CW'(16);
            end else if (cmd.div_step && div_cnt_reg != '0) begin
                div_cnt_reg <= div_cnt_reg - CW'(1);
            end
        end
    end

    // Item capture, restoring divider (one quotient bit a cycle), result
    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            ev_reg  <= in_mode;
            cap_reg <= in_capture;
        end
        if (cmd.div_start) begin
            quo_reg <= cap_reg;
            rem_reg <= 16'd0;
            div_reg <= (delay_factor_reg < FACTOR_MIN) ? FACTOR_MIN : delay_factor_reg;
        end else if (cmd.div_step) begin
            if (rem_shift >= {9'd0, div_reg}) begin
                rem_reg <= 16'(rem_shift - {9'd0, div_reg});
                quo_reg <= {quo_reg[14:0], 1'b1};
            end else begin
                rem_reg <= rem_shift[15:0];
                quo_reg <= {quo_reg[14:0], 1'b0};
            end
        end
        if (cmd.exec || cmd.finish) begin
            result_reg <= result_next;
        end else if (cmd.load_item) begin
            result_reg <= result_reg;
        end
    end

    // Unchanged-state events outside the capture path still output state
    assign result = result_reg;

endmodule

[rtl/sensorless_bldc_commutation_sequencer.sv]
// Top level of the sensorless BLDC six-step commutation sequencer
// Usage:
//   s_axis carries one event per beat: tuser holds the event mode, tdata the
//   capture count. m_axis returns exactly one result beat per event (field
//   layout beside the port). cfg_* writes one of eight registers by index.
// Sequencing:
//   The event is captured from the input beat, then executed into the result
//   register, and the registered result is shown on m_axis. A closed-loop
//   capture that passes the period check first runs the 16-step restoring
//   divide of period by delay factor, then a finish step. One event is in
//   flight at a time; s_axis_tready rises in the cycle after the result beat
//   is taken, so no new event is accepted before then.
// Reset:
//   aresetn low loads register defaults and puts the motor in off at step 0.
// Stall:
//   The result holds on m_axis while m_axis_tready is low and no new event
//   is taken until it leaves.
// Configuration is always accepted and must only be written while idle.
module sensorless_bldc_commutation_sequencer
    import sbc_pkg::*;
#(
    parameter int TIMER_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [15:0] capture_count
    input  logic [15:0] s_axis_tdata,
    // [2:0] mode
    input  logic [2:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [2:0] motor_state, [5:3] step_index, [6] drive_enabled, [8:7] high_phase,
    // [10:9] low_phase, [12:11] comparator_channel, [13] capture_rising,
    // [21:14] duty, [37:22] compare_value, [38] load_compare, [39] restart_timer
    output logic [39:0] m_axis_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [23:0] cfg_data
);

    dp_cmd_t    cmd;
    dp_status_t status;

    assign cfg_ready = 1'b1;

    sbc_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_beat   (s_axis_tvalid && s_axis_tready),
        .out_taken (m_axis_tready),
        .status    (status),
        .cmd       (cmd),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid)
    );

    sbc_datapath #(.TIMER_BITS(TIMER_BITS)) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .status     (status),
        .in_mode    (s_axis_tuser),
        .in_capture (s_axis_tdata),
        .cfg_we     (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .result     (m_axis_tdata)
    );

endmodule

[rtl/sbc_checker.sv]
// Port-level checker for the commutation sequencer, bound to the top level
`include "sensorless_bldc_commutation_sequencer_defines.svh"
module sbc_checker
    import sbc_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata
);

    // A stalled result holds
    `SBC_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
    // No new event while a result is pending
    `SBC_ASSERT_IMP(a_one_in_flight, aclk, aresetn, m_axis_tvalid, !s_axis_tready)
    // An accepted event never shows a result in the next cycle
    `SBC_ASSERT_NEXT(a_no_instant, aclk, aresetn, s_axis_tvalid && s_axis_tready, !m_axis_tvalid)
    // Drive is enabled exactly when the motor is not off
    `SBC_ASSERT_IMP(a_drive, aclk, aresetn, m_axis_tvalid, m_axis_tdata[6] == (m_axis_tdata[2:0] != 3'(MS_OFF)))

endmodule

bind sensorless_bldc_commutation_sequencer sbc_checker u_sbc_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
